FILE: sv/scrp_pkg.sv
// Package for the sparse complex row product block.
// Holds widths, the request codes and the item type passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scrp_pkg;

    localparam int IDX_W          = 10;
    localparam int DATA_W         = 32;
    localparam int ACC_W          = 64;
    localparam int NODE_WIDE_W    = 17;
    localparam int NODE_COUNT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_COND   = 2'd1,
        REQ_SUSC   = 2'd2,
        REQ_FINISH = 2'd3
    } req_kind_t;

    // One classified item: a matrix entry with its voltage, or a finish.
    typedef struct packed {
        req_kind_t                kind;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] volt_e;
        logic signed [DATA_W-1:0] volt_f;
        logic [IDX_W-1:0]         row;
    } scrp_op_t;

endpackage

`default_nettype wire

FILE: sv/scrp_if.sv
// Handshake channels of the sparse complex row product block.
// Request channel and result channel; depends on scrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scrp_req_if import scrp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         node_index;
    logic signed [DATA_W-1:0] coef;
    logic signed [DATA_W-1:0] volt_real;
    logic signed [DATA_W-1:0] volt_imag;
    logic [IDX_W-1:0]         row_index;

    modport source (output valid, req_type, node_index, coef, volt_real, volt_imag,
                    row_index, input ready);
    modport sink (input valid, req_type, node_index, coef, volt_real, volt_imag,
                  row_index, output ready);
endinterface

interface scrp_res_if import scrp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         row_node;
    logic signed [DATA_W-1:0] real_sum;
    logic signed [DATA_W-1:0] imag_sum;
    logic                     overflow;

    modport source (output valid, row_node, real_sum, imag_sum, overflow, input ready);
    modport sink (input valid, row_node, real_sum, imag_sum, overflow, output ready);
endinterface

`default_nettype wire

FILE: sv/scrp_front.sv
// Front end: accepts request items, performs voltage writes and reads the
// voltage stores for matrix entries. Depends on scrp_pkg and scrp_if.
`timescale 1ns / 1ps
`default_nettype none

module scrp_front import scrp_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    scrp_req_if.sink    req,
    output scrp_op_t    op,
    output logic        op_valid,
    input  wire logic   op_ready
);

    localparam int AW = $clog2(NODE_COUNT);

    logic [DATA_W-1:0] re_mem [NODE_COUNT];
    logic [DATA_W-1:0] im_mem [NODE_COUNT];

    logic                   accept;
    req_kind_t              kind;
    logic [NODE_WIDE_W-1:0] node_wide;
    logic                   in_range;
    logic [AW-1:0]          addr;
    logic                   wr_en;
    logic                   rd_en;
    logic                   push;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    req_kind_t              s1_kind_reg;
    logic signed [DATA_W-1:0] s1_coef_reg;
    logic [IDX_W-1:0]       s1_row_reg;
    logic                   s1_in_range_reg;
    logic [DATA_W-1:0]      e_rd_reg;
    logic [DATA_W-1:0]      f_rd_reg;

    assign kind      = req_kind_t'(req.req_type);
    assign node_wide = NODE_WIDE_W'(req.node_index);
    assign in_range  = node_wide < NODE_WIDE_W'(NODE_COUNT);
    assign addr      = node_wide[AW-1:0];

    assign push      = s1_valid_reg && op_ready;
    assign req.ready = !s1_valid_reg || op_ready;
    assign accept    = req.valid && req.ready;
    assign wr_en     = accept && (kind == REQ_WRITE) && in_range;
    assign rd_en     = accept && (kind != REQ_WRITE) && in_range;

    // Write items finish here; everything else waits in the stage register.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = (kind != REQ_WRITE);
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (kind != REQ_WRITE))
        begin
            s1_kind_reg     <= kind;
            s1_coef_reg     <= req.coef;
            s1_row_reg      <= req.row_index;
            s1_in_range_reg <= in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            re_mem[addr] <= req.volt_real;
            im_mem[addr] <= req.volt_imag;
        end
        if (rd_en)
        begin
            e_rd_reg <= re_mem[addr];
            f_rd_reg <= im_mem[addr];
        end
    end

    // A column beyond the store reads as a zero voltage.
    always_comb
    begin
        op.kind   = s1_kind_reg;
        op.coef   = s1_coef_reg;
        op.row    = s1_row_reg;
        op.volt_e = s1_in_range_reg ? e_rd_reg : '0;
        op.volt_f = s1_in_range_reg ? f_rd_reg : '0;
    end

    assign op_valid = s1_valid_reg;

endmodule

`default_nettype wire

FILE: sv/scrp_queue.sv
// Short queue between front and back ends of the row product block.
// Depends on scrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scrp_queue import scrp_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire scrp_op_t push_op,
    input  wire logic     push_valid,
    output logic          push_ready,
    output scrp_op_t      head_op,
    output logic          head_valid,
    input  wire logic     pop
);

    scrp_op_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

FILE: sv/scrp_back.sv
// Back end: multiplies entries by their voltages, accumulates the two sums
// with saturation and emits a row result on finish. Depends on scrp_pkg, scrp_if.
`timescale 1ns / 1ps
`default_nettype none

module scrp_back import scrp_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire scrp_op_t head_op,
    input  wire logic     head_valid,
    output logic          pop,
    scrp_res_if.source    rsp
);

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ovf;
    } acc_res_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } q16_res_t;

    localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int FRAC_W = DATA_W / 2;

    // Adds or subtracts a product; the product never reaches the most
    // negative value, so its negation is exact.
    function automatic acc_res_t sat_accumulate(input logic [ACC_W-1:0] acc,
                                                input logic [ACC_W-1:0] prod,
                                                input logic neg);
        logic [ACC_W-1:0] operand;
        logic [ACC_W:0]   sum;
        acc_res_t         res;
        operand   = neg ? ~prod : prod;
        sum       = {acc[ACC_W-1], acc} + {operand[ACC_W-1], operand} + (ACC_W+1)'(neg);
        res.ovf   = sum[ACC_W] ^ sum[ACC_W-1];
        res.value = res.ovf ? (acc[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
        return res;
    endfunction

    // Arithmetic shift by the fraction width, then clamp to the result range.
    function automatic q16_res_t to_q16(input logic [ACC_W-1:0] acc);
        q16_res_t res;
        res.sat   = !((&acc[ACC_W-1:FRAC_W+DATA_W-1]) || !(|acc[ACC_W-1:FRAC_W+DATA_W-1]));
        res.value = res.sat ? (acc[ACC_W-1] ? Q_MIN : Q_MAX) : acc[FRAC_W+DATA_W-1:FRAC_W];
        return res;
    endfunction

    logic                     m_valid_reg;
    req_kind_t                m_kind_reg;
    logic [IDX_W-1:0]         m_row_reg;
    logic signed [ACC_W-1:0]  m_prod_re_reg;
    logic signed [ACC_W-1:0]  m_prod_im_reg;
    logic                     m_neg_reg;

    logic [ACC_W-1:0]         acc_re_reg;
    logic [ACC_W-1:0]         acc_im_reg;
    logic                     sticky_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [DATA_W-1:0]        out_re_reg;
    logic [DATA_W-1:0]        out_im_reg;
    logic                     out_ovf_reg;

    logic                     out_free;
    logic                     m_retire;
    logic                     fin_retire;
    logic                     ent_retire;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    acc_res_t                 add_re;
    acc_res_t                 add_im;
    q16_res_t                 q_re;
    q16_res_t                 q_im;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign m_retire   = m_valid_reg && ((m_kind_reg != REQ_FINISH) || out_free);
    assign fin_retire = m_retire && (m_kind_reg == REQ_FINISH);
    assign ent_retire = m_retire && (m_kind_reg != REQ_FINISH);
    assign pop        = head_valid && (!m_valid_reg || m_retire);

    // Conductance pairs e with the real sum; susceptance swaps the voltage parts.
    always_comb
    begin
        unique case (head_op.kind) inside
            REQ_SUSC:
            begin
                op_a = head_op.volt_f;
                op_b = head_op.volt_e;
            end
            default:
            begin
                op_a = head_op.volt_e;
                op_b = head_op.volt_f;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_retire)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_kind_reg    <= head_op.kind;
            m_row_reg     <= head_op.row;
            m_neg_reg     <= (head_op.kind == REQ_SUSC);
            m_prod_re_reg <= head_op.coef * op_a;
            m_prod_im_reg <= head_op.coef * op_b;
        end
    end

    assign add_re = sat_accumulate(acc_re_reg, m_prod_re_reg, m_neg_reg);
    assign add_im = sat_accumulate(acc_im_reg, m_prod_im_reg, 1'b0);
    assign q_re   = to_q16(acc_re_reg);
    assign q_im   = to_q16(acc_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_retire)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
                sticky_reg <= 1'b0;
            end
            else if (ent_retire)
            begin
                acc_re_reg <= add_re.value;
                acc_im_reg <= add_im.value;
                sticky_reg <= sticky_reg || add_re.ovf || add_im.ovf;
            end
            if (fin_retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_retire)
        begin
            out_row_reg <= m_row_reg;
            out_re_reg  <= q_re.value;
            out_im_reg  <= q_im.value;
            out_ovf_reg <= sticky_reg || q_re.sat || q_im.sat;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.row_node = out_row_reg;
    assign rsp.real_sum = out_re_reg;
    assign rsp.imag_sum = out_im_reg;
    assign rsp.overflow = out_ovf_reg;

`ifndef SYNTHESIS
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fin_retire |=> (acc_re_reg == '0) && (acc_im_reg == '0) && !sticky_reg)
        else $error("row state not cleared after finish");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin_retire))
        else $error("result raised without a finish item");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_kind_reg == REQ_FINISH) && !out_free)
            |=> m_valid_reg && $stable(m_row_reg) && $stable(acc_re_reg))
        else $error("stalled finish lost its row state");
`endif

endmodule

`default_nettype wire

FILE: sv/sparse_complex_row_product.sv
// Top level of the sparse complex row product block.
// Depends on scrp_pkg, scrp_if, scrp_front, scrp_queue and scrp_back.
//
// Usage: request items arrive on req. A write item stores a node voltage
// (real and imaginary Q16.16 parts); conductance and susceptance items carry
// one matrix entry of the current row and its column node; a finish item
// closes the row. Only finish items produce a result on rsp: the row node,
// the two Q16.16 sums clamped to range, and a flag that is set if any
// accumulation or the final clamp saturated within the row.
// Throughput is one item per cycle while rsp does not stall; the limit is
// the single read port of the voltage stores and the one accumulate per
// cycle in the back end. Write items take effect in the cycle they are
// accepted, so a later entry for the same node sees the new value. While
// rsp is stalled, entries keep flowing and only a finish waits; once the
// two-entry queue and the front stage register fill, req.ready drops.
// Reset clears the sums, the flag and the valid bits of the pipeline;
// voltage entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sparse_complex_row_product import scrp_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scrp_req_if.sink   req,
    scrp_res_if.source rsp
);

    scrp_op_t front_op;
    logic     front_valid;
    logic     queue_ready;
    scrp_op_t head_op;
    logic     head_valid;
    logic     head_pop;

    scrp_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (queue_ready)
    );

    scrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .head_op    (head_op),
        .head_valid (head_valid),
        .pop        (head_pop)
    );

    scrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_op    (head_op),
        .head_valid (head_valid),
        .pop        (head_pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
